@@ rtl/core/kpv_pkg.sv @@
// Package for the two-state Kalman filter step: word format, register indexes,
// sequencer micro-ops and the request/response types of the arithmetic units.
// No dependencies.
`default_nettype none

package kpv_pkg;

  localparam int WORD_BITS = 64;
  localparam int FRAC_BITS = 32;
  localparam int REG_BITS  = 63;
  localparam int CFG_IDX_BITS = 3;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int HALF_BITS = WORD_BITS / 2;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int STEP_BITS = 5;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Register reset values (Q32.32)
  localparam logic [REG_BITS-1:0]  RST_STEP_DT   = 63'd429496730;
  localparam logic [REG_BITS-1:0]  RST_HALF_DT2  = 63'd21474836;
  localparam logic [REG_BITS-1:0]  RST_MEAS_VAR  = 63'd429496729600;
  localparam logic [REG_BITS-1:0]  RST_PROC_PP   = 63'd4295;
  localparam logic [WORD_BITS-1:0] RST_PROC_PV   = 64'd85899;
  localparam logic [REG_BITS-1:0]  RST_PROC_VV   = 63'd1717987;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_DT  = 3'd0,
    CFG_HALF_DT2 = 3'd1,
    CFG_MEAS_VAR = 3'd2,
    CFG_PROC_PP  = 3'd3,
    CFG_PROC_PV  = 3'd4,
    CFG_PROC_VV  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [4:0] {
    R_X, R_V, R_P00, R_P01, R_P11,
    R_DT, R_HDT2, R_SZ, R_SPP, R_SPV, R_SVV,
    R_Y, R_U, R_M, R_T1, R_XP, R_VP, R_INN, R_S, R_A0, R_K0, R_K1, R_T
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e src_a;
    reg_e src_b;
    reg_e dst;
  } uop_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } seq_st_e;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_PP,
    MS_ACC,
    MS_RND,
    MS_FIN
  } mul_st_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_RUN,
    DS_FIN
  } div_st_e;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] result;
    logic                 sat;
  } unit_rsp_t;

  localparam logic [STEP_BITS-1:0] LAST_STEP = 5'd28;

  // Micro-program of one filter step
  function automatic uop_t uop_at(input logic [STEP_BITS-1:0] step);
    uop_t u;
    u = '{op: OP_ADD, src_a: R_X, src_b: R_X, dst: R_T1};
    unique case (step)
      5'd0:  u = '{OP_MUL, R_DT,  R_V,    R_M};
      5'd1:  u = '{OP_ADD, R_X,   R_M,    R_T1};
      5'd2:  u = '{OP_MUL, R_HDT2, R_U,   R_M};
      5'd3:  u = '{OP_ADD, R_T1,  R_M,    R_XP};
      5'd4:  u = '{OP_MUL, R_DT,  R_U,    R_M};
      5'd5:  u = '{OP_ADD, R_V,   R_M,    R_VP};
      5'd6:  u = '{OP_SUB, R_Y,   R_XP,   R_INN};
      5'd7:  u = '{OP_ADD, R_P00, R_SZ,   R_S};
      5'd8:  u = '{OP_MUL, R_DT,  R_P01,  R_M};
      5'd9:  u = '{OP_ADD, R_P00, R_M,    R_A0};
      5'd10: u = '{OP_DIV, R_A0,  R_S,    R_K0};
      5'd11: u = '{OP_DIV, R_P01, R_S,    R_K1};
      5'd12: u = '{OP_MUL, R_K0,  R_INN,  R_M};
      5'd13: u = '{OP_ADD, R_XP,  R_M,    R_X};
      5'd14: u = '{OP_MUL, R_K1,  R_INN,  R_M};
      5'd15: u = '{OP_ADD, R_VP,  R_M,    R_V};
      5'd16: u = '{OP_MUL, R_DT,  R_P11,  R_M};
      5'd17: u = '{OP_ADD, R_P01, R_M,    R_T};
      5'd18: u = '{OP_MUL, R_DT,  R_T,    R_M};
      5'd19: u = '{OP_ADD, R_A0,  R_M,    R_T1};
      5'd20: u = '{OP_MUL, R_K0,  R_A0,   R_M};
      5'd21: u = '{OP_SUB, R_T1,  R_M,    R_T1};
      5'd22: u = '{OP_ADD, R_T1,  R_SPP,  R_P00};
      5'd23: u = '{OP_MUL, R_K1,  R_P01,  R_M};
      5'd24: u = '{OP_SUB, R_P11, R_M,    R_T1};
      5'd25: u = '{OP_ADD, R_T1,  R_SVV,  R_P11};
      5'd26: u = '{OP_MUL, R_K0,  R_P01,  R_M};
      5'd27: u = '{OP_SUB, R_T,   R_M,    R_T1};
      5'd28: u = '{OP_ADD, R_T1,  R_SPV,  R_P01};
      default: u = '{OP_ADD, R_X, R_X, R_T1};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/kpv_if.sv @@
// Valid/ready channel interfaces for measurements in and estimates out.
// Depends on kpv_pkg for the word width.
`default_nettype none

interface kpv_in_if;
  logic                          valid;
  logic                          ready;
  logic [kpv_pkg::WORD_BITS-1:0] measured_position;
  logic [kpv_pkg::WORD_BITS-1:0] accel_command;
  logic                          restart;
  modport source (output valid, measured_position, accel_command, restart, input ready);
  modport sink   (input valid, measured_position, accel_command, restart, output ready);
endinterface

interface kpv_out_if;
  logic                          valid;
  logic                          ready;
  logic [kpv_pkg::WORD_BITS-1:0] position_estimate;
  logic [kpv_pkg::WORD_BITS-1:0] velocity_estimate;
  logic [kpv_pkg::WORD_BITS-1:0] innovation;
  logic                          saturated;
  modport source (output valid, position_estimate, velocity_estimate, innovation, saturated,
                  input ready);
  modport sink   (input valid, position_estimate, velocity_estimate, innovation, saturated,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/kpv_mul.sv @@
// Saturating Q-format multiplier: one 32x32 multiplier over four partial products,
// then round to nearest (ties away from zero) and clamp. Depends on kpv_pkg.
`default_nettype none

module kpv_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  kpv_pkg::unit_req_t     req_i,
  output kpv_pkg::unit_rsp_t     rsp_o
);

  localparam int W = kpv_pkg::WORD_BITS;
  localparam int H = kpv_pkg::HALF_BITS;
  localparam int P = kpv_pkg::PROD_BITS;
  localparam int F = kpv_pkg::FRAC_BITS;

  kpv_pkg::mul_st_e state_q, state_d;
  logic [W-1:0] xa_q, xb_q;
  logic         neg_q;
  logic [1:0]   cnt_q;
  logic [W-1:0] pp_q;
  logic [P-1:0] acc_q;

  logic [H-1:0] hx, hy;
  logic [P-1:0] pp_shift;
  logic [W-1:0] mag_w, lim, res;
  logic         over;

  // Pick the halves for this partial product
  assign hx = cnt_q[1] ? xa_q[W-1:H] : xa_q[H-1:0];
  assign hy = cnt_q[0] ? xb_q[W-1:H] : xb_q[H-1:0];

  always_comb begin
    case (cnt_q)
      2'd0:    pp_shift = {{(P-W){1'b0}}, pp_q};
      2'd3:    pp_shift = {pp_q, {W{1'b0}}};
      default: pp_shift = {{(P-W-H){1'b0}}, pp_q, {H{1'b0}}};
    endcase
  end

  // Clamp the rounded magnitude and apply the sign
  assign mag_w = acc_q[F +: W];
  assign lim   = kpv_pkg::WORD_MAX + {{(W-1){1'b0}}, neg_q};
  assign over  = (|acc_q[P-1:F+W]) || (mag_w > lim);
  assign res   = over ? (neg_q ? kpv_pkg::WORD_MIN : kpv_pkg::WORD_MAX)
                      : (neg_q ? (~mag_w + {{(W-1){1'b0}}, 1'b1}) : mag_w);

  always_comb begin
    state_d = state_q;
    rsp_o   = '{done: 1'b0, result: res, sat: over};
    unique case (state_q)
      kpv_pkg::MS_IDLE: if (req_i.start) state_d = kpv_pkg::MS_PP;
      kpv_pkg::MS_PP:   state_d = kpv_pkg::MS_ACC;
      kpv_pkg::MS_ACC:  state_d = (cnt_q == 2'd3) ? kpv_pkg::MS_RND : kpv_pkg::MS_PP;
      kpv_pkg::MS_RND:  state_d = kpv_pkg::MS_FIN;
      kpv_pkg::MS_FIN: begin
        rsp_o.done = 1'b1;
        state_d    = kpv_pkg::MS_IDLE;
      end
      default: state_d = kpv_pkg::MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpv_pkg::MS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Operand magnitudes, partial product and accumulator
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kpv_pkg::MS_IDLE: begin
        xa_q  <= req_i.a[W-1] ? (~req_i.a + {{(W-1){1'b0}}, 1'b1}) : req_i.a;
        xb_q  <= req_i.b[W-1] ? (~req_i.b + {{(W-1){1'b0}}, 1'b1}) : req_i.b;
        neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
        acc_q <= '0;
        cnt_q <= 2'd0;
      end
      kpv_pkg::MS_PP:  pp_q <= {{(W-H){1'b0}}, hx} * {{(W-H){1'b0}}, hy};
      kpv_pkg::MS_ACC: begin
        acc_q <= acc_q + pp_shift;
        cnt_q <= cnt_q + 2'd1;
      end
      kpv_pkg::MS_RND: acc_q <= acc_q + {{(P-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/kpv_div.sv @@
// Restoring divider for the gain: (|a| << FRAC_BITS) / s, one quotient bit a cycle,
// truncated toward zero and clamped to the word. Depends on kpv_pkg.
`default_nettype none

module kpv_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  kpv_pkg::unit_req_t     req_i,
  output kpv_pkg::unit_rsp_t     rsp_o
);

  localparam int W  = kpv_pkg::WORD_BITS;
  localparam int N  = kpv_pkg::NUM_BITS;
  localparam int F  = kpv_pkg::FRAC_BITS;
  localparam int CW = $clog2(N);

  kpv_pkg::div_st_e state_q, state_d;
  logic [N-1:0]  num_q;
  logic [W-1:0]  rem_q, den_q, quo_q, lim, res;
  logic [CW-1:0] cnt_q;
  logic          neg_q, ovf_q, over;
  logic [W:0]    rs, diff;
  logic          ge;

  // One restoring step
  assign rs   = {rem_q, num_q[N-1]};
  assign diff = rs - {1'b0, den_q};
  assign ge   = rs >= {1'b0, den_q};

  assign lim  = kpv_pkg::WORD_MAX + {{(W-1){1'b0}}, neg_q};
  assign over = ovf_q || (quo_q > lim);
  assign res  = over ? (neg_q ? kpv_pkg::WORD_MIN : kpv_pkg::WORD_MAX)
                     : (neg_q ? (~quo_q + {{(W-1){1'b0}}, 1'b1}) : quo_q);

  always_comb begin
    state_d = state_q;
    rsp_o   = '{done: 1'b0, result: res, sat: over};
    unique case (state_q)
      kpv_pkg::DS_IDLE: if (req_i.start) state_d = kpv_pkg::DS_RUN;
      kpv_pkg::DS_RUN:  if (cnt_q == '0) state_d = kpv_pkg::DS_FIN;
      kpv_pkg::DS_FIN: begin
        rsp_o.done = 1'b1;
        state_d    = kpv_pkg::DS_IDLE;
      end
      default: state_d = kpv_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpv_pkg::DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kpv_pkg::DS_IDLE: begin
        num_q <= {(req_i.a[W-1] ? (~req_i.a + {{(W-1){1'b0}}, 1'b1}) : req_i.a), {F{1'b0}}};
        den_q <= req_i.b;
        neg_q <= req_i.a[W-1];
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        cnt_q <= CW'(N - 1);
      end
      kpv_pkg::DS_RUN: begin
        rem_q <= ge ? diff[W-1:0] : rs[W-1:0];
        quo_q <= {quo_q[W-2:0], ge};
        ovf_q <= ovf_q | quo_q[W-1];
        num_q <= {num_q[N-2:0], 1'b0};
        cnt_q <= cnt_q - {{(CW-1){1'b0}}, 1'b1};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/kalman_position_velocity_step.sv @@
// Top level of the two-state Kalman filter step: sequencer, state and config registers.
// Depends on kpv_pkg, kpv_if, kpv_mul and kpv_div.
`default_nettype none

// One measurement transaction runs one predictor-form Kalman step on a position and
// velocity estimate with a symmetric 2x2 covariance, all signed Q32.32 with saturation.
// A small sequencer walks 29 micro-ops through a saturating adder, a multiplier built on
// one 32x32 multiplier and a one-bit-a-cycle divider. A step runs two divides, eleven
// multiplications and 16 add/subtract micro-ops between accepting the measurement and
// loading the output register. With a nonpositive innovation variance the divides are
// skipped and both gains are written as zero. The input is not ready from the accept
// until the output register is loaded. A finished result waits in that register, and
// the next measurement is taken while it waits; a result still waiting when the
// following step ends holds the block until it is taken. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only while the block is
// idle, which the block itself does not enforce; unknown indexes are dropped. Setting
// restart clears the estimate and loads the covariance from the process noise
// registers before the step runs.
module kalman_position_velocity_step (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [kpv_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [kpv_pkg::WORD_BITS-1:0]       cfg_wdata_i,
  kpv_in_if.sink                                   meas_if,
  kpv_out_if.source                                est_if
);

  localparam int W = kpv_pkg::WORD_BITS;
  localparam int R = kpv_pkg::REG_BITS;

  // Configuration registers
  logic [R-1:0] dt_q, hdt2_q, sz_q, spp_q, svv_q;
  logic [W-1:0] spv_q;

  // Filter state and step temporaries
  logic [W-1:0] x_q, v_q, p00_q, p01_q, p11_q;
  logic [W-1:0] y_q, u_q, m_q, t1_q, xp_q, vp_q, inn_q, s_q, a0_q, k0_q, k1_q, t_q;
  logic         sat_q;

  kpv_pkg::seq_st_e state_q, state_d;
  logic [kpv_pkg::STEP_BITS-1:0] step_q;

  logic            out_valid_q;
  logic [W-1:0]    out_pos_q, out_vel_q, out_inn_q;
  logic            out_sat_q;

  kpv_pkg::uop_t     uop;
  logic [W-1:0]      opa, opb, add_res;
  logic [W:0]        sum;
  logic              add_ovf, s_pos;
  logic              wr_en, wr_sat, step_adv;
  logic [W-1:0]      wr_val;
  logic              mul_start, div_start;
  kpv_pkg::unit_req_t mul_req, div_req;
  kpv_pkg::unit_rsp_t mul_rsp, div_rsp;
  logic              accept, out_load;

  assign accept = meas_if.valid && meas_if.ready;
  assign uop    = kpv_pkg::uop_at(step_q);

  function automatic logic [W-1:0] rd(input kpv_pkg::reg_e sel,
      input logic [W-1:0] x, v, p00, p01, p11, y, u, m, t1, xp, vp, inn, s, a0, k0, k1, t,
      input logic [R-1:0] dt, hdt2, sz, spp, svv, input logic [W-1:0] spv);
    logic [W-1:0] r;
    r = '0;
    case (sel)
      kpv_pkg::R_X:    r = x;
      kpv_pkg::R_V:    r = v;
      kpv_pkg::R_P00:  r = p00;
      kpv_pkg::R_P01:  r = p01;
      kpv_pkg::R_P11:  r = p11;
      kpv_pkg::R_DT:   r = {1'b0, dt};
      kpv_pkg::R_HDT2: r = {1'b0, hdt2};
      kpv_pkg::R_SZ:   r = {1'b0, sz};
      kpv_pkg::R_SPP:  r = {1'b0, spp};
      kpv_pkg::R_SPV:  r = spv;
      kpv_pkg::R_SVV:  r = {1'b0, svv};
      kpv_pkg::R_Y:    r = y;
      kpv_pkg::R_U:    r = u;
      kpv_pkg::R_M:    r = m;
      kpv_pkg::R_T1:   r = t1;
      kpv_pkg::R_XP:   r = xp;
      kpv_pkg::R_VP:   r = vp;
      kpv_pkg::R_INN:  r = inn;
      kpv_pkg::R_S:    r = s;
      kpv_pkg::R_A0:   r = a0;
      kpv_pkg::R_K0:   r = k0;
      kpv_pkg::R_K1:   r = k1;
      kpv_pkg::R_T:    r = t;
      default:         r = '0;
    endcase
    return r;
  endfunction

  // Operand select
  assign opa = rd(uop.src_a, x_q, v_q, p00_q, p01_q, p11_q, y_q, u_q, m_q, t1_q, xp_q,
                  vp_q, inn_q, s_q, a0_q, k0_q, k1_q, t_q, dt_q, hdt2_q, sz_q, spp_q,
                  svv_q, spv_q);
  assign opb = rd(uop.src_b, x_q, v_q, p00_q, p01_q, p11_q, y_q, u_q, m_q, t1_q, xp_q,
                  vp_q, inn_q, s_q, a0_q, k0_q, k1_q, t_q, dt_q, hdt2_q, sz_q, spp_q,
                  svv_q, spv_q);

  // Saturating add / subtract
  assign sum     = (uop.op == kpv_pkg::OP_SUB) ? ({opa[W-1], opa} - {opb[W-1], opb})
                                               : ({opa[W-1], opa} + {opb[W-1], opb});
  assign add_ovf = sum[W] != sum[W-1];
  assign add_res = add_ovf ? (sum[W] ? kpv_pkg::WORD_MIN : kpv_pkg::WORD_MAX) : sum[W-1:0];
  assign s_pos   = !opb[W-1] && (opb != '0);

  assign mul_req = '{start: mul_start, a: opa, b: opb};
  assign div_req = '{start: div_start, a: opa, b: opb};

  kpv_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  kpv_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Sequencer: next state, unit starts and register writeback
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    wr_en     = 1'b0;
    wr_val    = add_res;
    wr_sat    = 1'b0;
    step_adv  = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      kpv_pkg::ST_IDLE: if (accept) state_d = kpv_pkg::ST_ISSUE;
      kpv_pkg::ST_ISSUE: begin
        case (uop.op)
          kpv_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_d   = kpv_pkg::ST_WAIT;
          end
          kpv_pkg::OP_DIV: begin
            if (s_pos) begin
              div_start = 1'b1;
              state_d   = kpv_pkg::ST_WAIT;
            end else begin
              // Nonpositive innovation variance: zero gain
              wr_en    = 1'b1;
              wr_val   = '0;
              wr_sat   = 1'b1;
              step_adv = 1'b1;
            end
          end
          default: begin
            wr_en    = 1'b1;
            wr_sat   = add_ovf;
            step_adv = 1'b1;
          end
        endcase
      end
      kpv_pkg::ST_WAIT: begin
        if (mul_rsp.done) begin
          wr_en    = 1'b1;
          wr_val   = mul_rsp.result;
          wr_sat   = mul_rsp.sat;
          step_adv = 1'b1;
          state_d  = kpv_pkg::ST_ISSUE;
        end else if (div_rsp.done) begin
          wr_en    = 1'b1;
          wr_val   = div_rsp.result;
          wr_sat   = div_rsp.sat;
          step_adv = 1'b1;
          state_d  = kpv_pkg::ST_ISSUE;
        end
      end
      kpv_pkg::ST_DONE: begin
        if (!out_valid_q || est_if.ready) begin
          out_load = 1'b1;
          state_d  = kpv_pkg::ST_IDLE;
        end
      end
      default: state_d = kpv_pkg::ST_IDLE;
    endcase
    if (step_adv && step_q == kpv_pkg::LAST_STEP) state_d = kpv_pkg::ST_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpv_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (step_adv) begin
        step_q <= step_q + {{(kpv_pkg::STEP_BITS-1){1'b0}}, 1'b1};
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (est_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= kpv_pkg::RST_STEP_DT;
      hdt2_q <= kpv_pkg::RST_HALF_DT2;
      sz_q   <= kpv_pkg::RST_MEAS_VAR;
      spp_q  <= kpv_pkg::RST_PROC_PP;
      spv_q  <= kpv_pkg::RST_PROC_PV;
      svv_q  <= kpv_pkg::RST_PROC_VV;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kpv_pkg::CFG_STEP_DT:  dt_q   <= cfg_wdata_i[R-1:0];
        kpv_pkg::CFG_HALF_DT2: hdt2_q <= cfg_wdata_i[R-1:0];
        kpv_pkg::CFG_MEAS_VAR: sz_q   <= cfg_wdata_i[R-1:0];
        kpv_pkg::CFG_PROC_PP:  spp_q  <= cfg_wdata_i[R-1:0];
        kpv_pkg::CFG_PROC_PV:  spv_q  <= cfg_wdata_i;
        kpv_pkg::CFG_PROC_VV:  svv_q  <= cfg_wdata_i[R-1:0];
        default: ;
      endcase
    end
  end

  // Filter state: restart on accept, writeback from the micro-ops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      v_q   <= '0;
      p00_q <= {1'b0, kpv_pkg::RST_PROC_PP};
      p01_q <= kpv_pkg::RST_PROC_PV;
      p11_q <= {1'b0, kpv_pkg::RST_PROC_VV};
      sat_q <= 1'b0;
    end else if (accept) begin
      sat_q <= 1'b0;
      if (meas_if.restart) begin
        x_q   <= '0;
        v_q   <= '0;
        p00_q <= {1'b0, spp_q};
        p01_q <= spv_q;
        p11_q <= {1'b0, svv_q};
      end
    end else if (wr_en) begin
      sat_q <= sat_q | wr_sat;
      case (uop.dst)
        kpv_pkg::R_X:   x_q   <= wr_val;
        kpv_pkg::R_V:   v_q   <= wr_val;
        kpv_pkg::R_P00: p00_q <= wr_val;
        kpv_pkg::R_P01: p01_q <= wr_val;
        kpv_pkg::R_P11: p11_q <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q <= meas_if.measured_position;
      u_q <= meas_if.accel_command;
    end else if (wr_en) begin
      case (uop.dst)
        kpv_pkg::R_M:   m_q   <= wr_val;
        kpv_pkg::R_T1:  t1_q  <= wr_val;
        kpv_pkg::R_XP:  xp_q  <= wr_val;
        kpv_pkg::R_VP:  vp_q  <= wr_val;
        kpv_pkg::R_INN: inn_q <= wr_val;
        kpv_pkg::R_S:   s_q   <= wr_val;
        kpv_pkg::R_A0:  a0_q  <= wr_val;
        kpv_pkg::R_K0:  k0_q  <= wr_val;
        kpv_pkg::R_K1:  k1_q  <= wr_val;
        kpv_pkg::R_T:   t_q   <= wr_val;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q <= x_q;
      out_vel_q <= v_q;
      out_inn_q <= inn_q;
      out_sat_q <= sat_q;
    end
  end

  assign meas_if.ready            = (state_q == kpv_pkg::ST_IDLE);
  assign est_if.valid             = out_valid_q;
  assign est_if.position_estimate = out_pos_q;
  assign est_if.velocity_estimate = out_vel_q;
  assign est_if.innovation        = out_inn_q;
  assign est_if.saturated         = out_sat_q;

endmodule

`default_nettype wire

@@ rtl/core/kpv_checker.sv @@
// Port-level checks for the Kalman filter step, bound to the top level.
// Depends on kpv_if through the top level's interface ports.
`default_nettype none

module kpv_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_saturated_i
);

  // Hold a result until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_saturated_i))
    else $error("result dropped or changed while stalled");

  // Go busy after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transaction");

  // A new result only appears at the end of a busy stretch
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without work");

endmodule

bind kalman_position_velocity_step kpv_checker u_kpv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (meas_if.valid),
  .in_ready_i     (meas_if.ready),
  .out_valid_i    (est_if.valid),
  .out_ready_i    (est_if.ready),
  .out_saturated_i(est_if.saturated)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for kalman_position_velocity_step: directed table, then
// randomized phases under several register settings, checked against a Q32.32 predictor.
// Depends on kpv_pkg, kpv_if and the filter RTL.
`timescale 1ns / 1ps

module tb;

  typedef logic signed [kpv_pkg::WORD_BITS-1:0] q_t;

  typedef struct {
    q_t   pos;
    q_t   vel;
    q_t   inn;
    logic sat;
  } estimate_t;

  typedef struct {
    q_t        meas;
    q_t        accel;
    logic      restart;
    logic      zero_regs;  // go idle and clear every register before this row
    logic      known;      // expected value typed in below
    estimate_t want;
  } stim_row_t;

  localparam logic [kpv_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
  localparam int  LIMIT_CYCLES = 2_000_000;
  localparam int  NUM_PHASES   = 6;
  localparam int  PHASE_ITEMS  = 140;
  localparam q_t  ONE          = 64'sh0000_0001_0000_0000;
  localparam q_t  QMAX         = kpv_pkg::WORD_MAX;
  localparam q_t  QMIN         = kpv_pkg::WORD_MIN;
  localparam logic [kpv_pkg::WORD_BITS-1:0] MAX63 = {1'b0, {63{1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [kpv_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [kpv_pkg::WORD_BITS-1:0] cfg_wdata_i = '0;

  kpv_in_if  meas_if ();
  kpv_out_if est_if ();

  kalman_position_velocity_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .meas_if     (meas_if),
    .est_if      (est_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of registers and filter state
  q_t   m_dt, m_hdt2, m_sz, m_spp, m_spv, m_svv;
  q_t   m_x, m_v, m_p00, m_p01, m_p11;
  logic clip_hit;

  estimate_t pending_est[$];
  int   errors = 0;
  int   n_checked = 0;
  int   n_restart = 0;
  int   n_sat = 0;
  int   cycles = 0;
  logic steady = 1'b0;  // no idling on either side while set

  function automatic q_t clamp65(logic signed [kpv_pkg::WORD_BITS:0] v);
    if (v > $signed({1'b0, QMAX})) begin
      clip_hit = 1'b1;
      return QMAX;
    end
    if (v < $signed({1'b1, QMIN})) begin
      clip_hit = 1'b1;
      return QMIN;
    end
    return v[kpv_pkg::WORD_BITS-1:0];
  endfunction

  function automatic q_t sat_add(q_t a, q_t b);
    return clamp65({a[63], a} + {b[63], b});
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    return clamp65({a[63], a} - {b[63], b});
  endfunction

  // Magnitude with sign to word, clipping at the signed limits
  function automatic q_t pack_mag(logic [127:0] m, logic neg);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000_0000_0000 : 128'h7fff_ffff_ffff_ffff;
    if (m > lim) begin
      clip_hit = 1'b1;
      return neg ? QMIN : QMAX;
    end
    return neg ? -m[63:0] : m[63:0];
  endfunction

  function automatic logic [63:0] mag(q_t a);
    return a < 0 ? -a : a;
  endfunction

  // Product rounded to nearest at the binary point, ties away from zero
  function automatic q_t fx_mul(q_t a, q_t b);
    logic [127:0] p;
    p = {64'b0, mag(a)} * {64'b0, mag(b)};
    p = (p + (128'd1 << (kpv_pkg::FRAC_BITS - 1))) >> kpv_pkg::FRAC_BITS;
    return pack_mag(p, (a < 0) != (b < 0));
  endfunction

  // Quotient truncated toward zero; divisor is positive
  function automatic q_t fx_div(q_t a, q_t s);
    logic [127:0] num;
    num = {64'b0, mag(a)} << kpv_pkg::FRAC_BITS;
    return pack_mag(num / {64'b0, s}, a < 0);
  endfunction

  function automatic estimate_t kalman_step(q_t y, q_t u, logic restart);
    estimate_t e;
    q_t xp, vp, inn, s, a0, a1, k0, k1, t, m00;
    clip_hit = 1'b0;
    k0 = '0;
    k1 = '0;
    if (restart) begin
      m_x = '0;
      m_v = '0;
      m_p00 = m_spp;
      m_p01 = m_spv;
      m_p11 = m_svv;
    end
    xp  = sat_add(sat_add(m_x, fx_mul(m_dt, m_v)), fx_mul(m_hdt2, u));
    vp  = sat_add(m_v, fx_mul(m_dt, u));
    inn = sat_sub(y, xp);
    s   = sat_add(m_p00, m_sz);
    a0  = sat_add(m_p00, fx_mul(m_dt, m_p01));
    a1  = m_p01;
    if (s > 0) begin
      k0 = fx_div(a0, s);
      k1 = fx_div(a1, s);
    end else begin
      clip_hit = 1'b1;
    end
    m_x = sat_add(xp, fx_mul(k0, inn));
    m_v = sat_add(vp, fx_mul(k1, inn));
    t   = sat_add(a1, fx_mul(m_dt, m_p11));
    m00 = sat_add(a0, fx_mul(m_dt, t));
    m_p00 = sat_add(sat_sub(m00, fx_mul(k0, a0)), m_spp);
    m_p01 = sat_add(sat_sub(t, fx_mul(k0, a1)), m_spv);
    m_p11 = sat_add(sat_sub(m_p11, fx_mul(k1, a1)), m_svv);
    e.pos = m_x;
    e.vel = m_v;
    e.inn = inn;
    e.sat = clip_hit;
    return e;
  endfunction

  // Write one register at the next edge; caller lowers the enable
  task automatic reg_write(logic [kpv_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [kpv_pkg::WORD_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      kpv_pkg::CFG_STEP_DT:  m_dt   = val & MAX63;
      kpv_pkg::CFG_HALF_DT2: m_hdt2 = val & MAX63;
      kpv_pkg::CFG_MEAS_VAR: m_sz   = val & MAX63;
      kpv_pkg::CFG_PROC_PP:  m_spp  = val & MAX63;
      kpv_pkg::CFG_PROC_PV:  m_spv  = val;
      kpv_pkg::CFG_PROC_VV:  m_svv  = val & MAX63;
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [kpv_pkg::WORD_BITS-1:0] dt,
                            logic [kpv_pkg::WORD_BITS-1:0] hdt2,
                            logic [kpv_pkg::WORD_BITS-1:0] sz,
                            logic [kpv_pkg::WORD_BITS-1:0] spp,
                            logic [kpv_pkg::WORD_BITS-1:0] spv,
                            logic [kpv_pkg::WORD_BITS-1:0] svv);
    reg_write(kpv_pkg::CFG_STEP_DT, dt);
    reg_write(kpv_pkg::CFG_HALF_DT2, hdt2);
    reg_write(kpv_pkg::CFG_MEAS_VAR, sz);
    reg_write(kpv_pkg::CFG_PROC_PP, spp);
    reg_write(kpv_pkg::CFG_PROC_PV, spv);
    reg_write(kpv_pkg::CFG_PROC_VV, svv);
    // unmapped index must be dropped
    reg_write(CFG_UNUSED, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every expected estimate is back, then let the block settle
  task automatic drain();
    while (pending_est.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Offer one measurement transaction; predict on acceptance
  task automatic send_meas(q_t y, q_t u, logic restart, logic known, estimate_t want);
    int gap;
    estimate_t e;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas_if.valid             <= 1'b1;
    meas_if.measured_position <= y;
    meas_if.accel_command     <= u;
    meas_if.restart           <= restart;
    do @(posedge clk_i); while (!meas_if.ready);
    e = kalman_step(y, u, restart);
    pending_est.insert(pending_est.size(), known ? want : e);
    if (restart) n_restart++;
  endtask

  // Receiver back-pressure
  initial begin
    int stall;
    est_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        est_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      est_if.ready <= 1'b1;
      do @(posedge clk_i); while (!est_if.valid);
    end
  end

  // Compare each estimate transaction with the oldest prediction
  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && est_if.valid && est_if.ready) begin
      if (pending_est.size() == 0) begin
        $display("%0t: unexpected estimate pos=%h vel=%h inn=%h sat=%b", $time,
                 est_if.position_estimate, est_if.velocity_estimate,
                 est_if.innovation, est_if.saturated);
        errors++;
      end else begin
        want = pending_est.pop_front();
        n_checked++;
        if (est_if.saturated) n_sat++;
        if (est_if.position_estimate !== want.pos) begin
          $display("%0t: position expected %h got %h", $time, want.pos,
                   est_if.position_estimate);
          errors++;
        end
        if (est_if.velocity_estimate !== want.vel) begin
          $display("%0t: velocity expected %h got %h", $time, want.vel,
                   est_if.velocity_estimate);
          errors++;
        end
        if (est_if.innovation !== want.inn) begin
          $display("%0t: innovation expected %h got %h", $time, want.inn,
                   est_if.innovation);
          errors++;
        end
        if (est_if.saturated !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat,
                   est_if.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d estimates outstanding", $time, pending_est.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Directed rows: measurement, acceleration, restart, zero regs, known, expected
  stim_row_t rows[] = '{
    '{'0, '0, 1'b1, 1'b0, 1'b1, '{'0, '0, '0, 1'b0}},
    '{ONE, '0, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{QMAX, '0, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{QMIN, '0, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{'0, QMAX, 1'b1, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{'0, QMIN, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{QMAX, QMAX, 1'b1, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{QMIN, QMIN, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{-64'sd1, -64'sd1, 1'b1, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{64'sh5555_5555_5555_5555, 64'shaaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0, 1'b0,
      '{'0, '0, '0, 1'b0}},
    '{3 * ONE, ONE, 1'b1, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{3 * ONE, ONE, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{-2 * ONE, -ONE, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    '{64'sd1, 64'sd1, 1'b0, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
    // zero variance: gains forced to zero, flag set
    '{5 * ONE, QMAX, 1'b1, 1'b1, 1'b1, '{'0, '0, 5 * ONE, 1'b1}},
    '{QMIN, QMIN, 1'b0, 1'b0, 1'b1, '{'0, '0, QMIN, 1'b1}},
    '{QMAX, ONE, 1'b0, 1'b0, 1'b1, '{'0, '0, QMAX, 1'b1}}
  };

  function automatic q_t small_signed(int shift);
    q_t r;
    r = {$urandom, $urandom};
    return r >>> shift;
  endfunction

  function automatic q_t corner_value();
    case ($urandom_range(0, 3))
      0: return QMAX;
      1: return QMIN;
      2: return '0;
      default: return -64'sd1;
    endcase
  endfunction

  initial begin
    q_t y, u;
    logic rs;
    int hold_at;
    estimate_t none;
    none = '{'0, '0, '0, 1'b0};
    meas_if.valid             = 1'b0;
    meas_if.measured_position = '0;
    meas_if.accel_command     = '0;
    meas_if.restart           = 1'b0;
    m_dt = {1'b0, kpv_pkg::RST_STEP_DT};
    m_hdt2 = {1'b0, kpv_pkg::RST_HALF_DT2};
    m_sz = {1'b0, kpv_pkg::RST_MEAS_VAR};
    m_spp = {1'b0, kpv_pkg::RST_PROC_PP};
    m_spv = kpv_pkg::RST_PROC_PV;
    m_svv = {1'b0, kpv_pkg::RST_PROC_VV};
    m_x = '0;
    m_v = '0;
    m_p00 = m_spp;
    m_p01 = m_spv;
    m_p11 = m_svv;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (rows[i]) begin
      if (rows[i].zero_regs) begin
        meas_if.valid <= 1'b0;
        drain();
        write_regs('0, '0, '0, '0, '0, '0);
      end
      send_meas(rows[i].meas, rows[i].accel, rows[i].restart, rows[i].known, rows[i].want);
    end

    // Random phases, one register setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      meas_if.valid <= 1'b0;
      drain();
      case (ph)
        0: write_regs({1'b0, kpv_pkg::RST_STEP_DT}, {1'b0, kpv_pkg::RST_HALF_DT2},
                      {1'b0, kpv_pkg::RST_MEAS_VAR}, {1'b0, kpv_pkg::RST_PROC_PP},
                      kpv_pkg::RST_PROC_PV, {1'b0, kpv_pkg::RST_PROC_VV});
        1: write_regs({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, QMAX, {64{1'b1}});
        2: write_regs(MAX63, '0, '0, '0, QMIN, MAX63);
        3: write_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        4: write_regs(64'($urandom_range(1, 32'hffff_ffff)), 64'($urandom),
                      {$urandom_range(0, 255), $urandom}, 64'($urandom), small_signed(40),
                      {$urandom_range(0, 15), $urandom});
        default: write_regs({1'b0, kpv_pkg::RST_STEP_DT}, {1'b0, kpv_pkg::RST_HALF_DT2},
                            ONE, 64'd4295, -64'sd85899, 64'd1717987);
      endcase
      steady  = (ph % 3 == 1);
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) steady = ~steady;
        // pause the sender until the block has answered everything
        if (n == hold_at) begin
          meas_if.valid <= 1'b0;
          drain();
        end
        rs = (n == 0) || ($urandom_range(0, 24) == 0);
        case ($urandom_range(0, 9))
          0: begin
            y = {$urandom, $urandom};
            u = {$urandom, $urandom};
          end
          1: begin
            y = corner_value();
            u = corner_value();
          end
          default: begin
            // track the current estimate with modest noise
            y = sat_add(m_x, small_signed($urandom_range(24, 40)));
            u = small_signed($urandom_range(26, 44));
          end
        endcase
        send_meas(y, u, rs, 1'b0, none);
      end
    end
    meas_if.valid <= 1'b0;
    drain();
    repeat (800) @(posedge clk_i);

    $display("Checked %0d estimates over %0d register settings: %0d restarts, %0d clipped.",
             n_checked, NUM_PHASES + 2, n_restart, n_sat);
    if (errors == 0 && pending_est.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d estimates missing", errors, pending_est.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kpv_pkg.sv
rtl/core/kpv_if.sv
rtl/core/kpv_mul.sv
rtl/core/kpv_div.sv
rtl/core/kalman_position_velocity_step.sv
rtl/core/kpv_checker.sv
tb/tb.sv
